[sv/pipt_pkg.sv]
// Shared types and constants for the point-in-polygon test block.
// No dependencies; every other file of the block but pipt_ram imports this package.
package pipt_pkg;

    // Table size and coordinate width.
    localparam int MAX_VERTICES = 1024;
    localparam int COORD_WIDTH  = 32;

    // Fixed widths of the command fields and the count register.
    localparam int VINDEX_W = 10;
    localparam int CFG_W    = 11;

    // Derived widths: table address, clamped count, differences and products.
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int NCNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W  = (ADDR_W > VINDEX_W) ? ADDR_W : VINDEX_W;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // Command queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TEST  = 1'b1
    } t_cmd;

    // One classified command as it waits in the queue.
    typedef struct packed {
        t_cmd                          cmd;
        logic [ADDR_W-1:0]             slot;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_item;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

[sv/pipt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pipt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/pipt_front.sv]
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on pipt_pkg.
module pipt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [9:0]            i_vertex_index,
    input  logic signed [31:0]    i_coord_x,
    input  logic signed [31:0]    i_coord_y,
    output pipt_pkg::t_head       o_head,
    input  logic                  i_pop
);
    import pipt_pkg::*;

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr;
    logic [QCNT_W-1:0]     r_count;

    logic                  accept;
    logic                  keep;
    logic                  push;
    logic                  pop;
    logic [IDX_W-1:0]      idx_wide;
    t_item                 item;

    // Classify the incoming transaction. Writes beyond the table are dropped.
    always_comb begin
        idx_wide  = IDX_W'(i_vertex_index);
        item.cmd  = t_cmd'(i_command);
        item.slot = ADDR_W'(idx_wide);
        item.x    = i_coord_x[COORD_WIDTH-1:0];
        item.y    = i_coord_y[COORD_WIDTH-1:0];
        keep      = (item.cmd == CMD_TEST) ||
                    ({1'b0, idx_wide} < (IDX_W + 1)'(MAX_VERTICES));
    end

    assign busy   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;
    assign push   = accept && keep;
    assign pop    = i_pop && (r_count != '0);

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

[sv/pipt_back.sv]
// Back end: stores vertices and walks the polygon edges for each test.
// Depends on pipt_pkg and pipt_ram.
module pipt_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pipt_pkg::t_head        i_head,
    output logic                   o_pop,
    input  logic                   i_cfg_valid,
    input  logic [10:0]            i_cfg_data,
    output logic                   o_res_valid,
    output logic                   o_inside_res
);
    import pipt_pkg::*;

    localparam int CW = COORD_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state                   r_state;
    logic [NCNT_W-1:0]        r_n;
    logic [ADDR_W-1:0]        r_addr;
    logic                     r_flag;
    logic                     r_res_valid;
    logic                     r_inside;

    // Pipeline control tags.
    logic                     r_rd_valid;
    logic                     r_rd_first;
    logic                     r_rd_last;
    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic                     r_s2_valid;
    logic                     r_s2_last;

    // Pipeline payload.
    logic signed [CW-1:0]     r_tx;
    logic signed [CW-1:0]     r_ty;
    logic signed [CW-1:0]     r_prev_x;
    logic signed [CW-1:0]     r_prev_y;
    logic signed [DIFF_W-1:0] r_a;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [DIFF_W-1:0] r_b;
    logic signed [DIFF_W-1:0] r_c;
    logic                     r_s1_straddle;
    logic signed [PROD_W-1:0] r_lhs;
    logic signed [PROD_W-1:0] r_rhs;
    logic                     r_s2_straddle;
    logic                     r_s2_dyneg;

    logic                     pop;
    logic                     is_test;
    logic                     we;
    logic                     issue_first;
    logic                     issue;
    logic                     issue_last;
    logic [ADDR_W-1:0]        last_addr;
    logic [ADDR_W-1:0]        raddr;
    logic [2*CW-1:0]          rdata;
    logic signed [CW-1:0]     xi;
    logic signed [CW-1:0]     yi;
    logic                     toggle;
    logic [NCNT_W-1:0]        cfg_n;

    // Read sequencing: vertex n-1 first, then vertices 0 through n-1.
    assign pop         = (r_state == S_IDLE) && i_head.valid;
    assign is_test     = (i_head.item.cmd == CMD_TEST);
    assign we          = pop && !is_test;
    assign last_addr   = ADDR_W'(r_n - NCNT_W'(1));
    assign issue_first = pop && is_test && (r_n != '0);
    assign issue_last  = (r_state == S_ISSUE) && (r_addr == last_addr);
    assign issue       = issue_first || (r_state == S_ISSUE);
    assign raddr       = (r_state == S_ISSUE) ? r_addr : last_addr;
    assign o_pop       = pop;

    // Clamp the vertex count to the table size.
    assign cfg_n = (32'(i_cfg_data) > 32'(MAX_VERTICES)) ?
                   NCNT_W'(MAX_VERTICES) : NCNT_W'(i_cfg_data);

    pipt_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_head.item.slot),
        .i_wdata ({i_head.item.x, i_head.item.y}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign xi = rdata[2*CW-1:CW];
    assign yi = rdata[CW-1:0];

    // Crossing test: the sense of the compare follows the sign of the y span.
    assign toggle = r_s2_valid && r_s2_straddle &&
                    (r_s2_dyneg ? (r_lhs > r_rhs) : (r_lhs < r_rhs));

    // Sequencer state, count register, inside flag and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_addr      <= '0;
            r_flag      <= 1'b0;
            r_res_valid <= 1'b0;
            r_inside    <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_rd_first  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_last   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_n <= cfg_n;
            end

            r_rd_valid <= issue;
            r_rd_first <= issue_first;
            r_rd_last  <= issue_last;
            r_s1_valid <= r_rd_valid && !r_rd_first;
            r_s1_last  <= r_rd_last;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;

            if (issue_first) begin
                r_flag <= 1'b0;
            end else if (toggle) begin
                r_flag <= ~r_flag;
            end

            r_res_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (issue_first) begin
                        r_addr  <= '0;
                        r_state <= S_ISSUE;
                    end else if (pop && is_test) begin
                        // Empty polygon: answer outside at once.
                        r_res_valid <= 1'b1;
                        r_inside    <= 1'b0;
                    end
                end
                S_ISSUE: begin
                    if (issue_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_s2_valid && r_s2_last) begin
                        r_res_valid <= 1'b1;
                        r_inside    <= r_flag ^ toggle;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Test point capture and the edge arithmetic pipeline.
    always_ff @(posedge i_clk) begin
        if (issue_first) begin
            r_tx <= i_head.item.x;
            r_ty <= i_head.item.y;
        end
        if (r_rd_valid) begin
            r_prev_x <= xi;
            r_prev_y <= yi;
        end
        // Edge from the previous vertex j to the current vertex i.
        r_a           <= DIFF_W'(r_tx) - DIFF_W'(xi);
        r_dy          <= DIFF_W'(r_prev_y) - DIFF_W'(yi);
        r_b           <= DIFF_W'(r_prev_x) - DIFF_W'(xi);
        r_c           <= DIFF_W'(r_ty) - DIFF_W'(yi);
        r_s1_straddle <= (yi > r_ty) != (r_prev_y > r_ty);
        // Cross-multiplied sides of the crossing compare.
        r_lhs         <= PROD_W'(r_a) * PROD_W'(r_dy);
        r_rhs         <= PROD_W'(r_b) * PROD_W'(r_c);
        r_s2_straddle <= r_s1_straddle;
        r_s2_dyneg    <= r_dy[DIFF_W-1];
    end

    assign o_res_valid  = r_res_valid;
    assign o_inside_res = r_inside;

endmodule

[sv/point_in_polygon_test_top.sv]
// Top level of the point-in-polygon test block.
// Depends on pipt_pkg, pipt_front and pipt_back.

// A vertex write transaction is stored in the back end and gives no result.
// A point test with a vertex count of n reads the vertex table once per cycle,
// n+1 reads in all, through a three-stage edge pipeline, and its result is
// registered when the last edge leaves that pipeline; with n zero the test
// answers outside straight from the idle state.
// The single read port of the vertex RAM sets this pace. A two-entry queue in
// front lets new commands be taken while a test is running; busy rises when it
// is full. Each result is shown for exactly one cycle on o_res_valid and cannot
// be held. The vertex count is written through the configuration channel, which
// is always ready, and should only be changed while no command is outstanding.
module point_in_polygon_test_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [9:0]         i_vertex_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [10:0]        i_cfg_data,
    output logic               o_res_valid,
    output logic               o_inside_res
);
    import pipt_pkg::*;

    t_head head;
    logic  pop;

    // Command intake and queue.
    pipt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_head         (head),
        .i_pop          (pop)
    );

    // Vertex store and edge walker.
    pipt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_res_valid  (o_res_valid),
        .o_inside_res (o_inside_res)
    );

    assign o_cfg_ready = 1'b1;

endmodule

[dv/pipt_inside_checker.sv]
// Checker for the point-in-polygon test block: it predicts and compares the inside flag.
// It depends on pipt_pkg and watches the command, configuration and result ports.
`timescale 1ns / 1ps

module pipt_inside_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_command,
    input  logic [pipt_pkg::VINDEX_W-1:0] i_vertex_index,
    input  logic signed [31:0]            i_coord_x,
    input  logic signed [31:0]            i_coord_y,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pipt_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_res_valid,
    input  logic                          i_inside_res,
    output int                            o_fail_count,
    output int                            o_tests_pending
);
    import pipt_pkg::*;

    // Shadow copy of the vertex table and the count register.
    logic signed [COORD_WIDTH-1:0] vtx_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vtx_y [MAX_VERTICES];
    logic [CFG_W-1:0]              vertex_count;

    // Inside flags of accepted tests, oldest first.
    logic inside_due [$];

    // Crossing-number parity of the stored polygon for one point. The crossing
    // compare is done exactly by multiplying through by the edge's y span.
    function automatic logic crossing_parity(input logic signed [COORD_WIDTH-1:0] px,
                                             input logic signed [COORD_WIDTH-1:0] py);
        int                         n;
        int                         i;
        int                         j;
        logic                       odd;
        logic                       above_i;
        logic                       above_j;
        logic signed [DIFF_W-1:0]   rise;
        logic signed [DIFF_W-1:0]   run_x;
        logic signed [DIFF_W-1:0]   to_px;
        logic signed [DIFF_W-1:0]   to_py;
        logic signed [PROD_W-1:0]   lhs;
        logic signed [PROD_W-1:0]   rhs;
        n   = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        odd = 1'b0;
        j   = n - 1;
        for (i = 0; i < n; i++) begin
            above_i = vtx_y[i] > py;
            above_j = vtx_y[j] > py;
            // Only edges that straddle the point's y can toggle the flag.
            if (above_i != above_j) begin
                rise  = vtx_y[j] - vtx_y[i];
                run_x = vtx_x[j] - vtx_x[i];
                to_px = px - vtx_x[i];
                to_py = py - vtx_y[i];
                lhs   = to_px * rise;
                rhs   = run_x * to_py;
                if ((rise > 0 && lhs < rhs) || (rise < 0 && lhs > rhs)) begin
                    odd = ~odd;
                end
            end
            j = i;
        end
        return odd;
    endfunction

    // Check results, then track configuration and accepted transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_count = '0;
            inside_due.delete();
            o_fail_count    = 0;
            o_tests_pending = 0;
        end else begin
            // A result at this edge belongs to a test accepted earlier.
            if (i_res_valid) begin
                if (inside_due.size() == 0) begin
                    $error("inside_res: result with no test waiting, actual %0d",
                           i_inside_res);
                    o_fail_count++;
                end else if (inside_due[0] !== i_inside_res) begin
                    $error("inside_res mismatch: expected %0d, actual %0d",
                           inside_due[0], i_inside_res);
                    o_fail_count++;
                    void'(inside_due.pop_front());
                end else begin
                    void'(inside_due.pop_front());
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                vertex_count = i_cfg_data;
            end

            if (i_start && !i_busy) begin
                if (i_command == CMD_TEST) begin
                    inside_due.push_back(crossing_parity(i_coord_x, i_coord_y));
                end else if (i_vertex_index < MAX_VERTICES) begin
                    vtx_x[i_vertex_index] = i_coord_x;
                    vtx_y[i_vertex_index] = i_coord_y;
                end
            end

            o_tests_pending = inside_due.size();
        end
    end

endmodule

[dv/tb_top.sv]
// Testbench top for the point-in-polygon test block: clock, reset, stimulus and verdict.
// It depends on pipt_pkg, point_in_polygon_test_top and pipt_inside_checker.
`timescale 1ns / 1ps

module tb_top;
    import pipt_pkg::*;

    localparam int RANDOM_ITEMS  = 560;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 3000000;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

    // How coordinates are spread.
    localparam int SPREAD_FULL    = 0;
    localparam int SPREAD_GRID    = 1;
    localparam int SPREAD_MID     = 2;
    localparam int SPREAD_EXTREME = 3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_command;
    logic [9:0]         i_vertex_index;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [10:0]        i_cfg_data;
    logic               o_res_valid;
    logic               o_inside_res;

    int fail_count;
    int tests_pending;
    int cycle_count;
    int items_sent;
    bit quiet;

    // Stimulus bookkeeping: what was written to each slot.
    logic signed [31:0] shape_x [MAX_VERTICES];
    logic signed [31:0] shape_y [MAX_VERTICES];

    point_in_polygon_test_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_res_valid    (o_res_valid),
        .o_inside_res   (o_inside_res)
    );

    pipt_inside_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_command       (i_command),
        .i_vertex_index  (i_vertex_index),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_res_valid     (o_res_valid),
        .i_inside_res    (o_inside_res),
        .o_fail_count    (fail_count),
        .o_tests_pending (tests_pending)
    );

    // Clock with an 8 ns period.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung block ends the run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_coord(input int spread);
        int v;
        case (spread)
            SPREAD_FULL: begin
                return $urandom;
            end
            SPREAD_GRID: begin
                v = $urandom_range(0, 8);
                return (v - 4) * 65536;
            end
            SPREAD_MID: begin
                v = $urandom_range(0, 2 ** 21);
                return v - 2 ** 20;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance, or after the gap.
    task automatic send_item(input t_cmd cmd, input int slot,
                             input logic signed [31:0] x, input logic signed [31:0] y);
        int gap;
        start          = 1'b1;
        i_command      = cmd;
        i_vertex_index = slot[9:0];
        i_coord_x      = x;
        i_coord_y      = y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cmd == CMD_WRITE) begin
            shape_x[slot] = x;
            shape_y[slot] = y;
        end
        items_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            // Fields carry noise while no transaction is offered.
            start          = 1'b0;
            i_command      = 1'($urandom_range(0, 1));
            i_vertex_index = 10'($urandom);
            i_coord_x      = $urandom;
            i_coord_y      = $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drain every test, then let any trailing vertex writes leave the block.
    task automatic settle();
        start = 1'b0;
        while (tests_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_count(input int value);
        settle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Test a point near the polygon: each coordinate is either a vertex value
    // (to hit ties) or drawn from the polygon's spread, now and then the full range.
    task automatic test_near(input int n, input int spread);
        logic signed [31:0] x;
        logic signed [31:0] y;
        x = pick_coord(spread);
        y = pick_coord(spread);
        if (n > 0 && $urandom_range(0, 2) == 0) begin
            x = shape_x[$urandom_range(0, n - 1)];
        end
        if (n > 0 && $urandom_range(0, 2) == 0) begin
            y = shape_y[$urandom_range(0, n - 1)];
        end
        if ($urandom_range(0, 9) == 0) begin
            x = pick_coord(SPREAD_FULL);
            y = pick_coord(SPREAD_FULL);
        end
        send_item(CMD_TEST, $urandom_range(0, 1023), x, y);
    endtask

    initial begin
        int first_random;
        int n;
        int r;
        int spread;
        int tests;
        int k;
        int s;

        start          = 1'b0;
        i_command      = CMD_WRITE;
        i_vertex_index = '0;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        items_sent     = 0;
        quiet          = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: an empty polygon always answers outside.
        set_count(0);
        send_item(CMD_TEST, 0, 0, 0);
        send_item(CMD_TEST, 1023, COORD_MAX, COORD_MIN);

        // Square on the extremes of the coordinate range, plus the last slot.
        send_item(CMD_WRITE, 0, COORD_MIN, COORD_MIN);
        send_item(CMD_WRITE, 1, COORD_MAX, COORD_MIN);
        send_item(CMD_WRITE, 2, COORD_MAX, COORD_MAX);
        send_item(CMD_WRITE, 3, COORD_MIN, COORD_MAX);
        send_item(CMD_WRITE, 1023, COORD_MAX, COORD_MIN);
        set_count(4);
        send_item(CMD_TEST, 0, 0, 0);
        send_item(CMD_TEST, 0, COORD_MIN, 0);
        send_item(CMD_TEST, 0, COORD_MAX, COORD_MAX);
        send_item(CMD_TEST, 0, COORD_MIN, COORD_MIN);
        // On a horizontal edge, then near the centre.
        send_item(CMD_TEST, 0, 0, COORD_MAX);
        send_item(CMD_TEST, 0, 1, -1);

        // Degenerate polygons: a single point and a doubled segment.
        set_count(1);
        send_item(CMD_TEST, 0, 0, 0);
        set_count(2);
        send_item(CMD_TEST, 0, 0, 0);
        // Triangle with a horizontal base.
        set_count(3);
        send_item(CMD_TEST, 0, COORD_MAX - 1, COORD_MIN + 2);
        send_item(CMD_TEST, 0, 0, 0);

        // Random polygons: write the vertices, set the count, then mostly tests.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            quiet  = ($urandom_range(0, 5) == 0);
            spread = $urandom_range(SPREAD_FULL, SPREAD_EXTREME);
            r      = $urandom_range(0, 99);
            if (r < 5) begin
                n = 0;
            end else if (r < 10) begin
                n = $urandom_range(1, 2);
            end else if (r < 80) begin
                n = $urandom_range(3, 12);
            end else if (r < 95) begin
                n = $urandom_range(13, 64);
            end else begin
                n = $urandom_range(65, 200);
            end
            for (s = 0; s < n; s++) begin
                send_item(CMD_WRITE, s, pick_coord(spread), pick_coord(spread));
            end
            set_count(n);
            tests = (n > 64) ? $urandom_range(2, 3) : $urandom_range(4, 12);
            for (k = 0; k < tests; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // Stray vertex write anywhere in the table.
                    send_item(CMD_WRITE, $urandom_range(0, 1023),
                              pick_coord(spread), pick_coord(spread));
                end else begin
                    test_near(n, spread);
                end
            end
        end

        settle();
        if (fail_count == 0 && tests_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
